>>> rtl/core/lrdc_pkg.sv
// Shared constants and types of the low-pass rate damping controller.
`timescale 1ns / 1ps

package lrdc_pkg;

	localparam int REG_W        = 31;
	localparam int CFG_ADDR_W   = 3;
	localparam int RATE_W       = 32;
	localparam int DT_W         = 16;
	localparam int OUT_W        = 32;
	localparam int DT_FRAC_BITS = 16;

	localparam int UMUL_W      = 32;
	localparam int DIGIT_W     = 4;
	localparam int DIGITS_FULL = UMUL_W / DIGIT_W;
	localparam int DIGITS_DT   = DT_W / DIGIT_W;
	localparam int CNT_W       = $clog2(DIGITS_FULL);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CUTOFF       = 3'd0,
		REG_ROLL_FORCE   = 3'd1,
		REG_ROLL_TORQUE  = 3'd2,
		REG_PITCH_FORCE  = 3'd3,
		REG_PITCH_TORQUE = 3'd4,
		REG_FILT_WEIGHT  = 3'd5,
		REG_RAW_WEIGHT   = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		STEP_XDOT   = 3'd0,
		STEP_XNEW   = 3'd1,
		STEP_FILT   = 3'd2,
		STEP_FWT    = 3'd3,
		STEP_SUM    = 3'd4,
		STEP_FORCE  = 3'd5,
		STEP_TORQUE = 3'd6
	} step_t;

endpackage

>>> rtl/core/lowpass_rate_damping_controller_top.sv
// Low-pass rate damping controller built around one digit-serial multiplier.
//
// Usage: configuration registers are written through cfg_wr_en, cfg_addr and
// cfg_wdata while the block is idle. An input item carries the roll rate, the
// pitch rate and the time step; it is taken when in_valid and in_ready are both
// high. Each item produces exactly one result item with the two damping forces
// and the two damping torques, offered on out_valid until out_ready takes it.
// All work goes through one shared multiplier that consumes the unsigned
// operand four bits per cycle. Each multiply runs through operand load, the
// digit steps and the shift and saturate stage; the time step multiply steps
// only through the digits of delta_t. Fourteen multiplies per item run one
// after another, and in_ready stays low until the result moves to the output.
// A new item is accepted while the previous result still waits at the output.
// When the receiver stalls, the finished result of the next item is held inside
// until the output register frees up. Reset clears both filter states, loads the
// register defaults and empties the output register.
`timescale 1ns / 1ps

module lowpass_rate_damping_controller_top
	import lrdc_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0]        cfg_addr,
	input  logic [REG_W-1:0]             cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [RATE_W-1:0]     roll_rate,
	input  logic signed [RATE_W-1:0]     pitch_rate,
	input  logic [DT_W-1:0]              delta_t,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [OUT_W-1:0]      force_x,
	output logic signed [OUT_W-1:0]      force_y,
	output logic signed [OUT_W-1:0]      torque_roll,
	output logic signed [OUT_W-1:0]      torque_pitch
);

	localparam int DW = DATA_WIDTH;
	localparam int BW = ((DW > RATE_W) ? DW : RATE_W) + 1;
	localparam int PW = BW + UMUL_W;
	localparam int PARTW = BW + DIGIT_W + 1;

	localparam logic signed [PW-1:0] P_DW_MAX  = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [PW-1:0] P_DW_MIN  = ~P_DW_MAX;
	localparam logic signed [PW-1:0] P_OUT_MAX = {{(PW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [PW-1:0] P_OUT_MIN = ~P_OUT_MAX;
	localparam logic signed [BW:0]   S_DW_MAX  = {{(BW-DW+2){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [BW:0]   S_DW_MIN  = ~S_DW_MAX;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_SHIFT,
		S_APPLY,
		S_FINISH
	} state_t;

	state_t                   state_q;
	step_t                    step_q;
	logic                     axis_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     dt_op_q;
	logic                     out_op_q;
	logic                     out_valid_q;

	logic [REG_W-1:0]         cutoff_q;
	logic [REG_W-1:0]         roll_kv_q;
	logic [REG_W-1:0]         roll_kw_q;
	logic [REG_W-1:0]         pitch_kv_q;
	logic [REG_W-1:0]         pitch_kw_q;
	logic [REG_W-1:0]         filt_wt_q;
	logic [REG_W-1:0]         raw_wt_q;

	logic signed [DW-1:0]     x_roll_q;
	logic signed [DW-1:0]     x_pitch_q;

	logic signed [RATE_W-1:0] roll_q;
	logic signed [RATE_W-1:0] pitch_q;
	logic [DT_W-1:0]          dt_q;
	logic [UMUL_W-1:0]        u_q;
	logic signed [BW-1:0]     b_q;
	logic signed [PW-1:0]     acc_q;
	logic signed [BW-1:0]     prod_q;
	logic signed [DW-1:0]     tmp_q;
	logic signed [DW-1:0]     fwt_q;
	logic signed [OUT_W-1:0]  fx_q;
	logic signed [OUT_W-1:0]  fy_q;
	logic signed [OUT_W-1:0]  tr_q;
	logic signed [OUT_W-1:0]  tp_q;
	logic signed [OUT_W-1:0]  force_x_q;
	logic signed [OUT_W-1:0]  force_y_q;
	logic signed [OUT_W-1:0]  torque_roll_q;
	logic signed [OUT_W-1:0]  torque_pitch_q;

	logic                     in_acc;
	logic                     out_load;
	logic signed [RATE_W-1:0] rate_cur;
	logic signed [DW-1:0]     x_cur;
	logic signed [BW-1:0]     rate_ext;
	logic signed [BW-1:0]     x_ext;
	logic signed [BW-1:0]     tmp_ext;
	logic [UMUL_W-1:0]        u_sel;
	logic signed [BW-1:0]     b_sel;
	logic                     dt_sel;
	logic                     out_sel;
	logic [DIGIT_W-1:0]       digit;
	logic signed [PARTW-1:0]  part;
	logic signed [PW-1:0]     acc_nxt;
	logic signed [PW-1:0]     shifted;
	logic signed [PW-1:0]     clamped;
	logic signed [BW:0]       sum_xdot;
	logic signed [BW:0]       sum_xnew;
	logic signed [BW:0]       sum_wt;
	logic signed [DW-1:0]     xdot_sat;
	logic signed [DW-1:0]     xnew_sat;
	logic signed [DW-1:0]     wt_sat;

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [BW:0] v);
		logic signed [BW:0] c;
		begin
			if (v > S_DW_MAX) begin
				c = S_DW_MAX;
			end else if (v < S_DW_MIN) begin
				c = S_DW_MIN;
			end else begin
				c = v;
			end
			return c[DW-1:0];
		end
	endfunction

	assign in_ready     = (state_q == S_IDLE);
	assign in_acc       = in_valid && in_ready;
	assign out_load     = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign out_valid    = out_valid_q;
	assign force_x      = force_x_q;
	assign force_y      = force_y_q;
	assign torque_roll  = torque_roll_q;
	assign torque_pitch = torque_pitch_q;

	assign rate_cur = axis_q ? pitch_q : roll_q;
	assign x_cur    = axis_q ? x_pitch_q : x_roll_q;
	assign rate_ext = {{(BW-RATE_W){rate_cur[RATE_W-1]}}, rate_cur};
	assign x_ext    = {{(BW-DW){x_cur[DW-1]}}, x_cur};
	assign tmp_ext  = {{(BW-DW){tmp_q[DW-1]}}, tmp_q};

	always_comb begin
		u_sel   = {1'b0, cutoff_q};
		b_sel   = x_ext;
		dt_sel  = 1'b0;
		out_sel = 1'b0;
		unique case (step_q)
			STEP_XDOT: begin
				u_sel = {1'b0, cutoff_q};
				b_sel = x_ext;
			end
			STEP_XNEW: begin
				u_sel  = {dt_q, {(UMUL_W-DT_W){1'b0}}};
				b_sel  = tmp_ext;
				dt_sel = 1'b1;
			end
			STEP_FILT: begin
				u_sel = {1'b0, cutoff_q};
				b_sel = tmp_ext;
			end
			STEP_FWT: begin
				u_sel = {1'b0, filt_wt_q};
				b_sel = tmp_ext;
			end
			STEP_SUM: begin
				u_sel = {1'b0, raw_wt_q};
				b_sel = rate_ext;
			end
			STEP_FORCE: begin
				u_sel   = {1'b0, (axis_q ? pitch_kv_q : roll_kv_q)};
				b_sel   = -tmp_ext;
				out_sel = 1'b1;
			end
			STEP_TORQUE: begin
				u_sel   = {1'b0, (axis_q ? pitch_kw_q : roll_kw_q)};
				b_sel   = -rate_ext;
				out_sel = 1'b1;
			end
			default: begin
				u_sel = {1'b0, cutoff_q};
				b_sel = x_ext;
			end
		endcase
	end

	assign digit   = u_q[UMUL_W-1 -: DIGIT_W];
	assign part    = b_q * $signed({1'b0, digit});
	assign acc_nxt = (acc_q <<< DIGIT_W) + {{(PW-PARTW){part[PARTW-1]}}, part};
	assign shifted = dt_op_q ? (acc_q >>> DT_FRAC_BITS) : (acc_q >>> FRAC_BITS);

	always_comb begin
		if (out_op_q) begin
			if (shifted > P_OUT_MAX) begin
				clamped = P_OUT_MAX;
			end else if (shifted < P_OUT_MIN) begin
				clamped = P_OUT_MIN;
			end else begin
				clamped = shifted;
			end
		end else begin
			if (shifted > P_DW_MAX) begin
				clamped = P_DW_MAX;
			end else if (shifted < P_DW_MIN) begin
				clamped = P_DW_MIN;
			end else begin
				clamped = shifted;
			end
		end
	end

	assign sum_xdot = {rate_ext[BW-1], rate_ext} - {prod_q[BW-1], prod_q};
	assign sum_xnew = {x_ext[BW-1], x_ext} + {prod_q[BW-1], prod_q};
	assign sum_wt   = {{(BW-DW+1){fwt_q[DW-1]}}, fwt_q} + {prod_q[BW-1], prod_q};
	assign xdot_sat = sat_dw(sum_xdot);
	assign xnew_sat = sat_dw(sum_xnew);
	assign wt_sat   = sat_dw(sum_wt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			step_q         <= STEP_XDOT;
			axis_q         <= 1'b0;
			cnt_q          <= '0;
			dt_op_q        <= 1'b0;
			out_op_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			cutoff_q       <= REG_W'(65536);
			roll_kv_q      <= '0;
			roll_kw_q      <= '0;
			pitch_kv_q     <= '0;
			pitch_kw_q     <= '0;
			filt_wt_q      <= REG_W'(65536);
			raw_wt_q       <= REG_W'(65536);
			x_roll_q       <= '0;
			x_pitch_q      <= '0;
			force_x_q      <= '0;
			force_y_q      <= '0;
			torque_roll_q  <= '0;
			torque_pitch_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					REG_CUTOFF:       cutoff_q   <= cfg_wdata;
					REG_ROLL_FORCE:   roll_kv_q  <= cfg_wdata;
					REG_ROLL_TORQUE:  roll_kw_q  <= cfg_wdata;
					REG_PITCH_FORCE:  pitch_kv_q <= cfg_wdata;
					REG_PITCH_TORQUE: pitch_kw_q <= cfg_wdata;
					REG_FILT_WEIGHT:  filt_wt_q  <= cfg_wdata;
					REG_RAW_WEIGHT:   raw_wt_q   <= cfg_wdata;
					default: begin
					end
				endcase
			end

			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						axis_q  <= 1'b0;
						step_q  <= STEP_XDOT;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					dt_op_q  <= dt_sel;
					out_op_q <= out_sel;
					cnt_q    <= dt_sel ? CNT_W'(DIGITS_DT - 1) : CNT_W'(DIGITS_FULL - 1);
					state_q  <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (step_q == STEP_XNEW) begin
						if (axis_q) begin
							x_pitch_q <= xnew_sat;
						end else begin
							x_roll_q <= xnew_sat;
						end
					end
					if (step_q == STEP_TORQUE) begin
						step_q <= STEP_XDOT;
						if (axis_q) begin
							state_q <= S_FINISH;
						end else begin
							axis_q  <= 1'b1;
							state_q <= S_LOAD;
						end
					end else begin
						step_q  <= step_t'(step_q + 3'd1);
						state_q <= S_LOAD;
					end
				end
				S_FINISH: begin
					if (out_load) begin
						force_x_q      <= fx_q;
						force_y_q      <= fy_q;
						torque_roll_q  <= tr_q;
						torque_pitch_q <= tp_q;
						out_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			roll_q  <= roll_rate;
			pitch_q <= pitch_rate;
			dt_q    <= delta_t;
		end
		if (state_q == S_LOAD) begin
			u_q   <= u_sel;
			b_q   <= b_sel;
			acc_q <= '0;
		end
		if (state_q == S_MUL) begin
			acc_q <= acc_nxt;
			u_q   <= u_q << DIGIT_W;
		end
		if (state_q == S_SHIFT) begin
			prod_q <= clamped[BW-1:0];
		end
		if (state_q == S_APPLY) begin
			unique case (step_q)
				STEP_XDOT:   tmp_q <= xdot_sat;
				STEP_XNEW:   tmp_q <= xnew_sat;
				STEP_FILT:   tmp_q <= prod_q[DW-1:0];
				STEP_FWT:    fwt_q <= prod_q[DW-1:0];
				STEP_SUM:    tmp_q <= wt_sat;
				STEP_FORCE: begin
					if (axis_q) begin
						fx_q <= prod_q[OUT_W-1:0];
					end else begin
						fy_q <= prod_q[OUT_W-1:0];
					end
				end
				STEP_TORQUE: begin
					if (axis_q) begin
						tp_q <= prod_q[OUT_W-1:0];
					end else begin
						tr_q <= prod_q[OUT_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the low-pass rate damping controller.
`timescale 1ns / 1ps

module testbench;
	import lrdc_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 229;
	localparam int LONG_HOLD = 1500;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES = 300;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam logic signed [RATE_W-1:0] RATE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [RATE_W-1:0] RATE_MIN = 32'sh8000_0000;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

	typedef logic [REG_RAW_WEIGHT:0][REG_W-1:0] reg_set_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] force_x;
		logic signed [OUT_W-1:0] force_y;
		logic signed [OUT_W-1:0] torque_roll;
		logic signed [OUT_W-1:0] torque_pitch;
	} damp_out_t;

	typedef enum int {
		SET_RESET,
		SET_TORQUE,
		SET_EXTREME,
		SET_NO_DECAY
	} dir_set_t;

	typedef struct {
		dir_set_t setting;
		logic signed [RATE_W-1:0] roll;
		logic signed [RATE_W-1:0] pitch;
		logic [DT_W-1:0] dt;
		bit typed;
		damp_out_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [REG_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic signed [RATE_W-1:0] roll_rate;
	logic signed [RATE_W-1:0] pitch_rate;
	logic [DT_W-1:0] delta_t;
	logic out_valid;
	logic out_ready;
	logic signed [OUT_W-1:0] force_x;
	logic signed [OUT_W-1:0] force_y;
	logic signed [OUT_W-1:0] torque_roll;
	logic signed [OUT_W-1:0] torque_pitch;

	reg_set_t regs_now;
	longint roll_state;
	longint pitch_state;
	damp_out_t damping_due [$];
	damp_out_t oldest;
	dir_row_t plan [$];
	int fails;
	int idle_cycles;
	int burst_left;
	int run_left;
	int stall_left;
	bit no_gaps;
	logic long_hold_req;
	logic signed [RATE_W-1:0] base_roll;
	logic signed [RATE_W-1:0] base_pitch;
	logic [DT_W-1:0] base_dt;

	lowpass_rate_damping_controller_top #(
		.DATA_WIDTH(32),
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.roll_rate(roll_rate),
		.pitch_rate(pitch_rate),
		.delta_t(delta_t),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.force_x(force_x),
		.force_y(force_y),
		.torque_roll(torque_roll),
		.torque_pitch(torque_pitch)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint clamp_q(longint v);
		if (v > Q_MAX)
			return Q_MAX;
		if (v < Q_MIN)
			return Q_MIN;
		return v;
	endfunction

	function automatic longint mul_q(longint a, longint b, int sh);
		return clamp_q((a * b) >>> sh);
	endfunction

	task automatic filter_axis(input longint rate, input longint dt, inout longint st,
			input longint kv, input longint kw, output longint lat_force,
			output longint torque);
		longint wc;
		longint xdot;
		longint filt;
		longint sum;
		wc = longint'(regs_now[REG_CUTOFF]);
		xdot = clamp_q(rate - mul_q(wc, st, FRAC_BITS));
		st = clamp_q(st + mul_q(dt, xdot, DT_FRAC_BITS));
		filt = mul_q(wc, st, FRAC_BITS);
		sum = clamp_q(mul_q(longint'(regs_now[REG_FILT_WEIGHT]), filt, FRAC_BITS)
			+ mul_q(longint'(regs_now[REG_RAW_WEIGHT]), rate, FRAC_BITS));
		lat_force = mul_q(kv, -sum, FRAC_BITS);
		torque = mul_q(kw, -rate, FRAC_BITS);
	endtask

	task automatic predict_damping(input logic signed [RATE_W-1:0] r,
			input logic signed [RATE_W-1:0] p, input logic [DT_W-1:0] d, output damp_out_t res);
		longint fx;
		longint fy;
		longint tr;
		longint tp;
		filter_axis(longint'(r), longint'(d), roll_state, longint'(regs_now[REG_ROLL_FORCE]),
			longint'(regs_now[REG_ROLL_TORQUE]), fy, tr);
		filter_axis(longint'(p), longint'(d), pitch_state, longint'(regs_now[REG_PITCH_FORCE]),
			longint'(regs_now[REG_PITCH_TORQUE]), fx, tp);
		res.force_x = fx[OUT_W-1:0];
		res.force_y = fy[OUT_W-1:0];
		res.torque_roll = tr[OUT_W-1:0];
		res.torque_pitch = tp[OUT_W-1:0];
	endtask

	function automatic logic signed [RATE_W-1:0] rand_rate();
		case ($urandom_range(0, 9))
			0: return RATE_MAX;
			1: return RATE_MIN;
			2: return $urandom_range(0, 1 << 19) - (1 << 18);
			3: return $urandom_range(0, 2) - 1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DT_W-1:0] rand_dt();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return DT_W'($urandom_range(1, 1000));
			default: return DT_W'($urandom);
		endcase
	endfunction

	function automatic logic [REG_W-1:0] pick_reg();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return '1;
			2: return 31'd65536;
			3: return REG_W'($urandom_range(0, 1 << 18));
			4: return REG_W'($urandom_range(0, 1 << 20));
			default: return REG_W'($urandom);
		endcase
	endfunction

	function automatic reg_set_t directed_settings(dir_set_t k);
		reg_set_t s;
		s = '0;
		s[REG_CUTOFF] = 31'd65536;
		s[REG_FILT_WEIGHT] = 31'd65536;
		s[REG_RAW_WEIGHT] = 31'd65536;
		case (k)
			SET_TORQUE: begin
				s[REG_ROLL_TORQUE] = 31'd65536;
				s[REG_PITCH_TORQUE] = 31'd65536;
			end
			SET_EXTREME: s = '1;
			SET_NO_DECAY: begin
				s[REG_CUTOFF] = '0;
				s[REG_ROLL_FORCE] = 31'd131072;
				s[REG_ROLL_TORQUE] = 31'd32768;
				s[REG_PITCH_FORCE] = 31'd65536;
				s[REG_PITCH_TORQUE] = 31'd196608;
				s[REG_FILT_WEIGHT] = 31'd32768;
				s[REG_RAW_WEIGHT] = 31'd98304;
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic add_row(input dir_set_t k, input logic signed [RATE_W-1:0] r,
			input logic signed [RATE_W-1:0] p, input logic [DT_W-1:0] d, input bit typed,
			input damp_out_t want);
		dir_row_t row;
		row.setting = k;
		row.roll = r;
		row.pitch = p;
		row.dt = d;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		if (idx <= REG_RAW_WEIGHT)
			regs_now[idx] = val;
	endtask

	task automatic apply_settings(input reg_set_t s);
		for (int i = REG_CUTOFF; i <= REG_RAW_WEIGHT; i++)
			write_reg(CFG_ADDR_W'(i), s[i]);
		write_reg(REG_SPARE, REG_W'($urandom));
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (damping_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic offer_tick(input logic signed [RATE_W-1:0] r,
			input logic signed [RATE_W-1:0] p, input logic [DT_W-1:0] d, input bit pinned,
			input damp_out_t pinned_out);
		damp_out_t calc;
		in_valid <= 1'b1;
		roll_rate <= r;
		pitch_rate <= p;
		delta_t <= d;
		do @(posedge clk); while (!in_ready);
		predict_damping(r, p, d, calc);
		damping_due.push_back(pinned ? pinned_out : calc);
		@(negedge clk);
	endtask

	task automatic after_item();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			base_roll = rand_rate();
			base_pitch = rand_rate();
			base_dt = rand_dt();
			gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic check_field(input string name, input logic signed [OUT_W-1:0] want,
			input logic signed [OUT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (damping_due.size() == 0) begin
				$error("result item with no expectation waiting");
				fails++;
			end else begin
				oldest = damping_due.pop_front();
				check_field("force_x", oldest.force_x, force_x);
				check_field("force_y", oldest.force_y, force_y);
				check_field("torque_roll", oldest.torque_roll, torque_roll);
				check_field("torque_pitch", oldest.torque_pitch, torque_pitch);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		run_left = 0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req <= 1'b0;
				run_left = 0;
				stall_left = LONG_HOLD;
			end
			if (run_left == 0 && stall_left == 0) begin
				run_left = $urandom_range(1, 500);
				stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
			end
			if (run_left > 0) begin
				out_ready <= 1'b1;
				run_left--;
			end else begin
				out_ready <= 1'b0;
				stall_left--;
			end
		end
	end

	initial begin
		damp_out_t typ;
		dir_set_t cur_set;
		reg_set_t s;
		logic signed [RATE_W-1:0] r;
		logic signed [RATE_W-1:0] p;
		logic [DT_W-1:0] d;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		roll_rate = '0;
		pitch_rate = '0;
		delta_t = '0;
		long_hold_req = 1'b0;
		fails = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		burst_left = 1;
		base_roll = '0;
		base_pitch = '0;
		base_dt = '0;
		regs_now = directed_settings(SET_RESET);
		roll_state = 0;
		pitch_state = 0;

		typ = '0;
		add_row(SET_RESET, '0, '0, '0, 1'b1, typ);
		add_row(SET_RESET, RATE_MAX, RATE_MIN, '1, 1'b1, typ);
		add_row(SET_RESET, RATE_MIN, RATE_MAX, 16'h0001, 1'b1, typ);
		add_row(SET_RESET, -32'sd1, 32'sd1, 16'h8000, 1'b1, typ);
		add_row(SET_RESET, RATE_MAX, RATE_MAX, '1, 1'b1, typ);
		add_row(SET_RESET, RATE_MIN, RATE_MIN, '1, 1'b1, typ);
		typ.torque_roll = RATE_MAX;
		typ.torque_pitch = 32'sh8000_0001;
		add_row(SET_TORQUE, RATE_MIN, RATE_MAX, 16'h0100, 1'b1, typ);
		typ.torque_roll = -32'sd65536;
		typ.torque_pitch = '0;
		add_row(SET_TORQUE, 32'sd65536, '0, '0, 1'b1, typ);
		typ.torque_roll = -32'sd1;
		typ.torque_pitch = 32'sd1;
		add_row(SET_TORQUE, 32'sd1, -32'sd1, '1, 1'b1, typ);
		typ = '0;
		add_row(SET_EXTREME, RATE_MAX, RATE_MIN, '1, 1'b0, typ);
		add_row(SET_EXTREME, RATE_MIN, RATE_MAX, '0, 1'b0, typ);
		add_row(SET_EXTREME, '0, '0, 16'h0001, 1'b0, typ);
		add_row(SET_EXTREME, RATE_MAX, RATE_MAX, '1, 1'b0, typ);
		add_row(SET_EXTREME, 32'sd12345, -32'sd54321, 16'd65, 1'b0, typ);
		add_row(SET_NO_DECAY, 32'sd65536, -32'sd65536, 16'h4000, 1'b0, typ);
		add_row(SET_NO_DECAY, 32'sd65536, -32'sd65536, 16'h4000, 1'b0, typ);
		add_row(SET_NO_DECAY, 32'sd65536, -32'sd65536, 16'h4000, 1'b0, typ);
		add_row(SET_NO_DECAY, RATE_MIN, RATE_MAX, '1, 1'b0, typ);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		cur_set = SET_RESET;
		foreach (plan[k]) begin
			if (plan[k].setting != cur_set) begin
				drain();
				apply_settings(directed_settings(plan[k].setting));
				cur_set = plan[k].setting;
			end
			offer_tick(plan[k].roll, plan[k].pitch, plan[k].dt, plan[k].typed, plan[k].want);
			after_item();
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			if (ph == 0)
				s = '0;
			else if (ph == RAND_PHASES - 1)
				s = '1;
			else
				for (int i = REG_CUTOFF; i <= REG_RAW_WEIGHT; i++)
					s[i] = pick_reg();
			apply_settings(s);
			no_gaps = (ph == 3 || ph == 6);
			if (ph == 2)
				long_hold_req <= 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 4 && n == PHASE_ITEMS / 2)
					drain();
				if ($urandom_range(0, 9) < 6) begin
					r = base_roll + ($urandom_range(0, 2047) - 1024);
					p = base_pitch + ($urandom_range(0, 2047) - 1024);
					d = base_dt;
				end else begin
					r = rand_rate();
					p = rand_rate();
					d = rand_dt();
				end
				offer_tick(r, p, d, 1'b0, typ);
				after_item();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0 && damping_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
